// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [CpW-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpQuestion    = 21'h00003F;

  // continuation byte tag, top two bits of the byte
  localparam logic [1:0] ContTag = 2'b10;

  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
    logic             skip;
  } dec_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
  } dec_result_t;

endpackage

// ===== rtl/utf8d_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Valid/ready channel carrying one UTF-8 byte per item.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [utf8d_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/utf8d_cp_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_cp_if
// Valid/ready channel carrying one decoded code point per item.
// ----------------------------------------------------------------------------
interface utf8d_cp_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::CpW-1:0]    code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

// ===== rtl/utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// UTF-8 byte stream to code point decoder, one byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and gives one code point per completed character.
// A byte passes an input register, is decoded against the sequence state in
// one short step and its code point, if any, lands in the output register,
// so throughput is one byte per cycle while the sink keeps ready high.
// Lead bytes 0x00-0x7F give themselves, stray 0x80-0xBF give '?', 0xC0-0xF7
// open 2 to 4 byte sequences whose following bytes are taken unchecked (low
// six bits each), and 0xF8-0xFF give U+FFFD and drop the 0x80-0xBF bytes
// right after. Bytes that complete nothing give no item.
module utf8_codepoint_decoder (
  input  logic                clk,
  input  logic                rst,
  utf8d_byte_if.sink          byte_ch,
  utf8d_cp_if.source          cp_ch
);

  logic                          s1_valid;
  logic [utf8d_pkg::ByteW-1:0]   s1_byte;
  logic                          s1_advance;
  logic                          o_valid;
  logic                          o_valid_next;
  logic                          o_load;
  logic [utf8d_pkg::CpW-1:0]     o_code;
  utf8d_pkg::dec_state_t         state;
  utf8d_pkg::dec_state_t         state_next;
  utf8d_pkg::dec_result_t        result;

  assign s1_advance    = !o_valid || cp_ch.ready;
  assign byte_ch.ready = !s1_valid || s1_advance;

  assign o_load       = s1_valid && s1_advance && result.emit;
  assign o_valid_next = o_load || (o_valid && !cp_ch.ready);

  assign cp_ch.valid      = o_valid;
  assign cp_ch.code_point = o_code;

  utf8d_step u_step (
    .state      (state),
    .data_byte  (s1_byte),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
    if (byte_ch.valid && byte_ch.ready) begin
      s1_byte <= byte_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= '0;
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
      if (s1_valid && s1_advance) begin
        state <= state_next;
      end
      if (o_load) begin
        o_code <= result.code_point;
      end
    end
  end

  // never mid-sequence and skipping at once
  a_pend_skip: assert property (@(posedge clk) disable iff (rst)
    state.pending != 2'd0 |-> !state.skip)
    else $error("pending sequence while skipping");

  // an empty output register never stalls the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> byte_ch.ready)
    else $error("input stalled with empty output");

  // ascii lead with no sequence open comes straight out
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance && state.pending == 2'd0 && !s1_byte[7]
    |=> o_valid && o_code == {13'd0, $past(s1_byte)})
    else $error("ascii byte not passed through");

  // a completed character produces an item
  a_complete: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance && state.pending == 2'd1 |=> o_valid)
    else $error("completed sequence gave no item");

endmodule

// ===== rtl/utf8d_step.sv =====
// ----------------------------------------------------------------------------
// utf8d_step
// Decoder next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::dec_state_t         state,
  input  logic [utf8d_pkg::ByteW-1:0]   data_byte,
  output utf8d_pkg::dec_state_t         state_next,
  output utf8d_pkg::dec_result_t        result
);

  always_comb begin
    state_next        = state;
    result.emit       = 1'b0;
    result.code_point = '0;
    if (state.pending != '0) begin
      // unchecked continuation, low six bits shifted in
      state_next.partial = {state.partial[utf8d_pkg::CpW-7:0], data_byte[5:0]};
      state_next.pending = state.pending - 2'd1;
      if (state.pending == 2'd1) begin
        result.emit       = 1'b1;
        result.code_point = {state.partial[utf8d_pkg::CpW-7:0], data_byte[5:0]};
      end
    end else if (state.skip && data_byte[7:6] == utf8d_pkg::ContTag) begin
      // trailing bytes after a bad lead are dropped
    end else begin
      state_next.skip = 1'b0;
      if (!data_byte[7]) begin
        result.emit       = 1'b1;
        result.code_point = {13'd0, data_byte};
      end else if (!data_byte[6]) begin
        result.emit       = 1'b1;
        result.code_point = utf8d_pkg::CpQuestion;
      end else if (!data_byte[5]) begin
        state_next.partial = {16'd0, data_byte[4:0]};
        state_next.pending = 2'd1;
      end else if (!data_byte[4]) begin
        state_next.partial = {17'd0, data_byte[3:0]};
        state_next.pending = 2'd2;
      end else if (!data_byte[3]) begin
        state_next.partial = {18'd0, data_byte[2:0]};
        state_next.pending = 2'd3;
      end else begin
        state_next.skip   = 1'b1;
        result.emit       = 1'b1;
        result.code_point = utf8d_pkg::CpReplacement;
      end
    end
  end

endmodule

// ===== tb/tb_utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Self-checking bench for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
// Bytes go in over the byte channel with random gaps, and code points are
// taken from the code point channel with random stalls. Every accepted byte
// runs through a local decoder that keeps its own copy of the sequence state
// and queues the code point it should produce. Each code point from the
// block is then compared with the oldest queued one. Directed tests cover
// single bytes, complete sequences, unchecked continuations and invalid
// leads. A long random stream of mostly well-formed characters follows.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder;

  typedef logic [utf8d_pkg::ByteW-1:0] byte_t;
  typedef logic [utf8d_pkg::CpW-1:0]   cp_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 400;
  localparam int unsigned MaxWait     = 6;
  localparam int unsigned SettleTicks = 8;

  logic clk;
  logic rst;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_codepoint_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .cp_ch   (cp_ch)
  );

  // local decoder state
  logic [utf8d_pkg::PendW-1:0] cp_pending;
  cp_t                         cp_partial;
  logic                        skip_trail;
  cp_t                         cp_expected[$];

  bit          src_idle;
  bit          snk_idle;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned bytes_dropped;
  int unsigned cps_checked;
  int unsigned cycle_count;
  cp_t         cp_want;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned draw_wait(input bit enable);
    return enable ? $urandom_range(0, MaxWait) : 0;
  endfunction

  // updates the local state for one byte, returns 1 if the byte is dropped
  function automatic bit decode_byte(input byte_t b);
    if (cp_pending != '0) begin
      cp_partial = {cp_partial[utf8d_pkg::CpW-7:0], b[5:0]};
      cp_pending = cp_pending - 2'd1;
      if (cp_pending == '0) cp_expected.push_back(cp_partial);
      return 1'b0;
    end
    if (skip_trail && b[7:6] == utf8d_pkg::ContTag) return 1'b1;
    skip_trail = 1'b0;
    casez (b)
      8'b0???????: cp_expected.push_back(cp_t'(b));
      8'b10??????: cp_expected.push_back(utf8d_pkg::CpQuestion);
      8'b110?????: begin
        cp_partial = cp_t'(b[4:0]);
        cp_pending = 2'd1;
      end
      8'b1110????: begin
        cp_partial = cp_t'(b[3:0]);
        cp_pending = 2'd2;
      end
      8'b11110???: begin
        cp_partial = cp_t'(b[2:0]);
        cp_pending = 2'd3;
      end
      default: begin
        skip_trail = 1'b1;
        cp_expected.push_back(utf8d_pkg::CpReplacement);
      end
    endcase
    return 1'b0;
  endfunction

  function automatic byte_t cont_byte();
    return {utf8d_pkg::ContTag, 6'($urandom)};
  endfunction

  // lead byte opening a sequence of len bytes, len from 2 to 4
  function automatic byte_t lead_byte(input int unsigned len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = draw_wait(src_idle);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    if (decode_byte(b)) bytes_dropped++;
  endtask

  task automatic send_bytes(input byte_t seq[]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // hold the byte channel until every queued code point has come out
  task automatic wait_drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (cp_expected.size() != 0);
  endtask

  task automatic test_single_bytes();
    send_bytes('{8'h00, 8'h7F, 8'h80, 8'hBF});
  endtask

  task automatic test_sequences();
    send_bytes('{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
    send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80});
    // largest value a 4-byte sequence can carry
    send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
  endtask

  task automatic test_unchecked_continuation();
    // ascii and lead bytes inside a sequence only lend their low six bits
    send_bytes('{8'hE0, 8'h41, 8'hFF});
  endtask

  task automatic test_invalid_lead();
    send_bytes('{8'hF8, 8'h80, 8'hBF, 8'h41});
    // a lead right after an invalid one ends the skip and is decoded
    send_bytes('{8'hFF, 8'hC3, 8'hA9});
    wait_drain();
  endtask

  task automatic send_random_char();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_byte(byte_t'($urandom_range(0, 127)));
    end else if (pick < 80) begin
      len = (pick < 45) ? 2 : (pick < 65) ? 3 : 4;
      send_byte(lead_byte(len));
      repeat (len - 1) send_byte(cont_byte());
    end else if (pick < 85) begin
      send_byte(cont_byte());
    end else if (pick < 92) begin
      send_byte({5'b11111, 3'($urandom)});
      repeat ($urandom_range(0, 3)) send_byte(cont_byte());
    end else if (pick < 96) begin
      // sequence with arbitrary bytes where continuations belong
      len = $urandom_range(2, 4);
      send_byte(lead_byte(len));
      repeat (len - 1) send_byte(byte_t'($urandom));
    end else begin
      send_byte(byte_t'($urandom));
    end
  endtask

  task automatic test_random_stream();
    int unsigned phase_end;
    for (int phase = 0; phase < 4; phase++) begin
      src_idle  = (phase == 0) || (phase == 2);
      snk_idle  = (phase == 0) || (phase == 3);
      phase_end = bytes_sent - bytes_dropped + PhaseBytes;
      while (bytes_sent - bytes_dropped < phase_end) send_random_char();
      wait_drain();
    end
  endtask

  // code point sink with random stalls
  initial begin
    int unsigned stall;
    cp_ch.ready = 1'b0;
    forever begin
      stall = draw_wait(snk_idle);
      if (stall != 0) begin
        cp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(cp_ch.valid && cp_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && cp_ch.valid && cp_ch.ready) begin
      cps_checked++;
      if (cp_expected.size() == 0) begin
        $display("%0t: code point with none expected: expected none, actual 0x%06h",
                 $time, cp_ch.code_point);
        errors++;
      end else begin
        cp_want = cp_expected.pop_front();
        if (cp_ch.code_point !== cp_want) begin
          $display("%0t: code_point mismatch: expected 0x%06h, actual 0x%06h",
                   $time, cp_want, cp_ch.code_point);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d code points still due",
               $time, cycle_count, cp_expected.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cp_pending        = '0;
    cp_partial        = '0;
    skip_trail        = 1'b0;
    src_idle          = 1'b1;
    snk_idle          = 1'b1;
    errors            = 0;
    bytes_sent        = 0;
    bytes_dropped     = 0;
    cps_checked       = 0;
    cycle_count       = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_single_bytes();
    test_sequences();
    test_unchecked_continuation();
    test_invalid_lead();
    test_random_stream();

    wait_drain();
    repeat (SettleTicks) @(posedge clk);
    if (cp_expected.size() != 0) begin
      $display("%0t: %0d code points never came out", $time, cp_expected.size());
      errors++;
    end
    $display("bytes accepted: %0d, of which %0d dropped after invalid leads",
             bytes_sent, bytes_dropped);
    $display("code points checked: %0d, mismatches: %0d", cps_checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== utf8_codepoint_decoder.f =====
rtl/utf8d_pkg.sv
rtl/utf8d_byte_if.sv
rtl/utf8d_cp_if.sv
rtl/utf8d_step.sv
rtl/utf8_codepoint_decoder.sv
tb/tb_utf8_codepoint_decoder.sv
